// ----- src/stack_calculator_engine_defines.svh -----
// shared assertion macros for the stack calculator engine
`ifndef STACK_CALCULATOR_ENGINE_DEFINES_SVH
`define STACK_CALCULATOR_ENGINE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define SCE_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// invariant checked on every rising clock edge outside reset
`define SCE_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) \
        else $error(msg);

`endif

// ----- src/sce_pkg.sv -----
package sce_pkg;

    localparam int WORD_W        = 32;
    localparam int OP_W          = 3;
    localparam int STATUS_W      = 3;
    localparam int DEPTH_W       = 9;
    localparam int S_TDATA_W     = 40;
    localparam int M_TDATA_W     = 48;
    localparam int STACK_DEPTH_D = 256;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_POP  = 3'd1,
        OP_ADD  = 3'd2,
        OP_SUB  = 3'd3,
        OP_DIV  = 3'd4,
        OP_MULT = 3'd5,
        OP_OUT  = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FEW     = 3'd1,
        ST_FULL    = 3'd2,
        ST_NEGPUSH = 3'd3,
        ST_NEGDIFF = 3'd4,
        ST_DIVZERO = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_ctrl_t;

endpackage

// ----- src/stack_calculator_engine.sv -----
// stack calculator engine: reverse-polish calculator over a fixed-depth stack
// input channel s_*: one request per operation, tdata = {pad, push_value, operation}
//   operation 0 push, 1 pop, 2 add, 3 sub, 4 div, 5 mult, 6 out, 7 no-op
// result channel m_*: exactly one result per request, in request order
//   tdata = {pad, depth_after, out_value, status}, tuser = out_valid
// arithmetic pops top T and second S, pushes T op S (32-bit wrap, div toward zero)
// refused requests (too few entries, full, negative push/difference, div by zero)
// leave the stack unchanged and report zero in out_value
// states from accept to result: push/no-op check then emit, pop/out add a pop state,
//   arithmetic adds load-T, load-S and calc; mult/div step the shared adder per bit
// one request at a time: s_tready is high only while the sequencer is idle
//   so a new request is taken only once the sequencer has finished the last one
// the result sits in an output register, so a new request is taken while it waits;
// a stalled receiver holds the next result in the sequencer until the slot frees
// reset (aresetn low at a clock edge) empties the stack and drops any pending result;
// stack memory is not cleared, only entries below the count are ever read
`include "stack_calculator_engine_defines.svh"

module stack_calculator_engine import sce_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_D
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [2:0] operation, [34:3] push_value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [2:0] status, [34:3] out_value,
                                            // [43:35] depth_after
    output logic                 m_tuser    // [0] out_valid
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int M_USED_W = STATUS_W + WORD_W + DEPTH_W;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_POP,
        S_LOAD_T,
        S_LOAD_S,
        S_CALC,
        S_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [CW-1:0]          count_reg, count_next;      // stack entries
    logic [OP_W-1:0]        op_reg, op_next;            // latched operation
    logic [WORD_W-1:0]      pv_reg, pv_next;            // latched push value
    logic [WORD_W-1:0]      top_reg, top_next;          // top entry T
    status_t                status_reg, status_next;
    logic [WORD_W-1:0]      value_reg, value_next;
    logic                   flag_reg, flag_next;        // out succeeded
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                   m_tuser_reg, m_tuser_next;

    // stack memory ports
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [WORD_W-1:0]      ram_wdata, ram_rdata;

    // shared arithmetic unit
    alu_ctrl_t              alu_ctrl;
    logic                   alu_done;
    logic [WORD_W-1:0]      alu_result;

    // stack pointers below the count
    logic [CW-1:0]          cnt_m1, cnt_m2;
    logic [CW+DEPTH_W-1:0]  depth_ext;
    op_t                    op_cur;

    assign cnt_m1    = count_reg - CW'(1);
    assign cnt_m2    = count_reg - CW'(2);
    assign depth_ext = {{DEPTH_W{1'b0}}, count_reg};
    assign op_cur    = op_t'(op_reg);

    sce_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sce_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (alu_ctrl),
        .a_in    (top_reg),
        .b_in    (ram_rdata),
        .done    (alu_done),
        .result  (alu_result)
    );

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        pv_next       = pv_reg;
        top_next      = top_reg;
        status_next   = status_reg;
        value_next    = value_reg;
        flag_next     = flag_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        ram_we        = 1'b0;
        ram_waddr     = cnt_m2[AW-1:0];
        ram_wdata     = alu_result;
        ram_raddr     = cnt_m1[AW-1:0];
        alu_ctrl      = '{start: 1'b0, op: ALU_ADD};

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tdata[OP_W-1:0];
                    pv_next    = s_tdata[OP_W +: WORD_W];
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                // read of the top entry is issued here for pop and arithmetic
                status_next = ST_OK;
                value_next  = '0;
                flag_next   = 1'b0;
                state_next  = S_EMIT;
                case (op_cur)
                    OP_PUSH: begin
                        if (pv_reg[WORD_W-1]) begin
                            status_next = ST_NEGPUSH;
                        end else if (count_reg == CW'(STACK_DEPTH)) begin
                            status_next = ST_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[AW-1:0];
                            ram_wdata  = pv_reg;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_POP, OP_OUT: begin
                        if (count_reg == '0) begin
                            status_next = ST_FEW;
                        end else begin
                            state_next = S_POP;
                        end
                    end
                    OP_ADD, OP_SUB, OP_DIV, OP_MULT: begin
                        if (count_reg < CW'(2)) begin
                            status_next = ST_FEW;
                        end else begin
                            state_next = S_LOAD_T;
                        end
                    end
                    default: ;  // unused code: no operation
                endcase
            end
            S_POP: begin
                value_next = ram_rdata;
                flag_next  = (op_cur == OP_OUT);
                count_next = cnt_m1;
                state_next = S_EMIT;
            end
            S_LOAD_T: begin
                // latch T, fetch S
                top_next   = ram_rdata;
                ram_raddr  = cnt_m2[AW-1:0];
                state_next = S_LOAD_S;
            end
            S_LOAD_S: begin
                if (op_cur == OP_DIV && ram_rdata == '0) begin
                    status_next = ST_DIVZERO;
                    state_next  = S_EMIT;
                end else begin
                    alu_ctrl.start = 1'b1;
                    case (op_cur)
                        OP_SUB:  alu_ctrl.op = ALU_SUB;
                        OP_DIV:  alu_ctrl.op = ALU_DIV;
                        OP_MULT: alu_ctrl.op = ALU_MUL;
                        default: alu_ctrl.op = ALU_ADD;
                    endcase
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                if (alu_done) begin
                    state_next = S_EMIT;
                    if (op_cur == OP_SUB && alu_result[WORD_W-1]) begin
                        status_next = ST_NEGDIFF;
                    end else begin
                        // result replaces S, T is dropped
                        ram_we     = 1'b1;
                        count_next = cnt_m1;
                        value_next = alu_result;
                    end
                end
            end
            S_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = {{(M_TDATA_W - M_USED_W){1'b0}},
                                     depth_ext[DEPTH_W-1:0], value_reg, status_reg};
                    m_tuser_next  = flag_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        op_reg      <= op_next;
        pv_reg      <= pv_next;
        top_reg     <= top_next;
        status_reg  <= status_next;
        value_reg   <= value_next;
        flag_reg    <= flag_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // stack never holds more than its depth
    `SCE_ASSERT_ALWAYS(a_count_range, aclk, aresetn, count_reg <= CW'(STACK_DEPTH),
        "stack count beyond depth")

    // the shared unit only finishes while the sequencer waits for it
    `SCE_ASSERT_IMPL(a_alu_done_calc, aclk, aresetn, alu_done, state_reg == S_CALC,
        "arithmetic unit finished outside calc state")

    // count moves by one entry at most per request
    `SCE_ASSERT_IMPL(a_count_step, aclk, aresetn,
        $past(aresetn) && count_reg != $past(count_reg),
        count_reg == $past(count_reg) + CW'(1) || count_reg + CW'(1) == $past(count_reg),
        "stack count jumped by more than one")

    // a refused request reports zero and no output flag
    `SCE_ASSERT_IMPL(a_refused_zero, aclk, aresetn,
        m_tvalid && m_tdata[STATUS_W-1:0] != ST_OK,
        m_tdata[STATUS_W +: WORD_W] == '0 && !m_tuser,
        "refused request carries a value")

endmodule

// ----- src/sce_ram.sv -----
module sce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/sce_alu.sv -----
module sce_alu import sce_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  alu_ctrl_t         ctrl,
    input  logic [WORD_W-1:0] a_in,
    input  logic [WORD_W-1:0] b_in,
    output logic              done,
    output logic [WORD_W-1:0] result
);

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

    typedef enum logic [1:0] {
        P_IDLE,
        P_ADDSUB,
        P_ITER,
        P_FIX
    } phase_t;

    phase_t            phase_reg, phase_next;
    alu_op_t           op_reg, op_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] mcand_reg, mcand_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              done_reg, done_next;
    logic [WORD_W-1:0] res_reg, res_next;

    logic [WORD_W-1:0] add_x, add_y, shifted;
    logic              add_cin;
    logic [WORD_W:0]   sum;

    assign shifted = {acc_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
    assign sum     = {1'b0, add_x} + {1'b0, add_y} + {{WORD_W{1'b0}}, add_cin};

    // the one shared adder: add, subtract, shift-add multiply, restoring divide and its sign fix
    always_comb begin
        add_x   = acc_reg;
        add_y   = '0;
        add_cin = 1'b0;
        case (phase_reg)
            P_ADDSUB: begin
                add_x   = mcand_reg;
                add_y   = (op_reg == ALU_SUB) ? ~quo_reg : quo_reg;
                add_cin = (op_reg == ALU_SUB);
            end
            P_ITER: begin
                if (op_reg == ALU_DIV) begin
                    add_x   = shifted;
                    add_y   = ~mcand_reg;
                    add_cin = 1'b1;
                end else begin
                    add_x = acc_reg;
                    add_y = quo_reg[0] ? mcand_reg : '0;
                end
            end
            P_FIX: begin
                add_x   = '0;
                add_y   = ~quo_reg;
                add_cin = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        op_next    = op_reg;
        acc_next   = acc_reg;
        quo_next   = quo_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        case (phase_reg)
            P_IDLE: begin
                if (ctrl.start) begin
                    op_next  = ctrl.op;
                    cnt_next = '0;
                    acc_next = '0;
                    case (ctrl.op)
                        ALU_ADD, ALU_SUB: begin
                            mcand_next = a_in;
                            quo_next   = b_in;
                            phase_next = P_ADDSUB;
                        end
                        ALU_MUL: begin
                            mcand_next = a_in;
                            quo_next   = b_in;
                            phase_next = P_ITER;
                        end
                        default: begin
                            // divide on magnitudes, sign fixed at the end
                            quo_next   = a_in[WORD_W-1] ? (~a_in + 1'b1) : a_in;
                            mcand_next = b_in[WORD_W-1] ? (~b_in + 1'b1) : b_in;
                            neg_next   = a_in[WORD_W-1] ^ b_in[WORD_W-1];
                            phase_next = P_ITER;
                        end
                    endcase
                end
            end
            P_ADDSUB: begin
                res_next   = sum[WORD_W-1:0];
                done_next  = 1'b1;
                phase_next = P_IDLE;
            end
            P_ITER: begin
                cnt_next = cnt_reg + 1'b1;
                if (op_reg == ALU_DIV) begin
                    acc_next = sum[WORD_W] ? sum[WORD_W-1:0] : shifted;
                    quo_next = {quo_reg[WORD_W-2:0], sum[WORD_W]};
                    if (cnt_reg == CNT_LAST) begin
                        if (neg_reg) begin
                            phase_next = P_FIX;
                        end else begin
                            res_next   = {quo_reg[WORD_W-2:0], sum[WORD_W]};
                            done_next  = 1'b1;
                            phase_next = P_IDLE;
                        end
                    end
                end else begin
                    acc_next   = sum[WORD_W-1:0];
                    mcand_next = {mcand_reg[WORD_W-2:0], 1'b0};
                    quo_next   = {1'b0, quo_reg[WORD_W-1:1]};
                    if (cnt_reg == CNT_LAST) begin
                        res_next   = sum[WORD_W-1:0];
                        done_next  = 1'b1;
                        phase_next = P_IDLE;
                    end
                end
            end
            P_FIX: begin
                res_next   = sum[WORD_W-1:0];
                done_next  = 1'b1;
                phase_next = P_IDLE;
            end
            default: phase_next = P_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
        op_reg    <= op_next;
        acc_reg   <= acc_next;
        quo_reg   <= quo_next;
        mcand_reg <= mcand_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        res_reg   <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- sim/tb_top.sv -----
module tb_top import sce_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // code 7 is not part of op_t: the block treats it as a no-op
    localparam logic [OP_W-1:0] OPC_NOP = 3'd7;
    localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 60;
    localparam int RANDOM_REQUESTS = 330;

    typedef struct packed {
        status_t              status;
        logic [WORD_W-1:0]    value;
        logic                 valid;
        logic [DEPTH_W-1:0]   depth;
    } calc_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;    // [2:0] operation, [34:3] push_value
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [2:0] status, [34:3] out_value,
                                           // [43:35] depth_after
    logic                 m_tuser;         // [0] out_valid

    // shadow copy of the calculator stack
    logic [WORD_W-1:0] calc_stack [STACK_DEPTH_D];
    int                calc_depth = 0;

    calc_result_t pending_results[$];
    calc_result_t want;
    int           error_count = 0;

    // idling controls for the sender and the receiver, and the watchdog counter
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int rx_gap;
    int quiet_cycles = 0;

    stack_calculator_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // apply one operation to the shadow stack, return what the block must report
    function automatic calc_result_t execute_op(logic [OP_W-1:0] opc,
                                                logic [WORD_W-1:0] pv);
        calc_result_t      r;
        logic [WORD_W-1:0] top;
        logic [WORD_W-1:0] sec;
        logic [WORD_W-1:0] res;
        logic [WORD_W-1:0] mag_top;
        logic [WORD_W-1:0] mag_sec;
        logic [WORD_W-1:0] quo;
        r.status = ST_OK;
        r.value  = '0;
        r.valid  = 1'b0;
        res      = '0;
        case (opc)
            OP_PUSH: begin
                if (pv[WORD_W-1]) begin
                    r.status = ST_NEGPUSH;
                end else if (calc_depth >= STACK_DEPTH_D) begin
                    r.status = ST_FULL;
                end else begin
                    calc_stack[calc_depth] = pv;
                    calc_depth++;
                end
            end
            OP_POP, OP_OUT: begin
                if (calc_depth < 1) begin
                    r.status = ST_FEW;
                end else begin
                    calc_depth--;
                    r.value = calc_stack[calc_depth];
                    r.valid = (opc == OP_OUT);
                end
            end
            OP_ADD, OP_SUB, OP_DIV, OP_MULT: begin
                if (calc_depth < 2) begin
                    r.status = ST_FEW;
                end else begin
                    top = calc_stack[calc_depth-1];
                    sec = calc_stack[calc_depth-2];
                    case (opc)
                        OP_ADD: res = top + sec;
                        OP_SUB: begin
                            res = top - sec;
                            if (res[WORD_W-1]) r.status = ST_NEGDIFF;
                        end
                        OP_DIV: begin
                            if (sec == '0) begin
                                r.status = ST_DIVZERO;
                            end else begin
                                // divide magnitudes, then fix the sign (toward zero)
                                mag_top = top[WORD_W-1] ? ('0 - top) : top;
                                mag_sec = sec[WORD_W-1] ? ('0 - sec) : sec;
                                quo = mag_top / mag_sec;
                                res = (top[WORD_W-1] != sec[WORD_W-1]) ? ('0 - quo) : quo;
                            end
                        end
                        default: res = top * sec;
                    endcase
                    if (r.status == ST_OK) begin
                        calc_depth--;
                        calc_stack[calc_depth-1] = res;
                        r.value = res;
                    end
                end
            end
            default: ;
        endcase
        r.depth = calc_depth[DEPTH_W-1:0];
        return r;
    endfunction

    // offer one request, hold it until taken, then record its expected result
    task automatic send_request(input logic [OP_W-1:0] opc, input logic [WORD_W-1:0] pv);
        int gap;
        gap = tx_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-OP_W-WORD_W){1'b0}}, pv, opc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(execute_op(opc, pv));
    endtask

    // non-negative push values, biased toward small numbers and the top of range
    function automatic logic [WORD_W-1:0] pick_push_value();
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return $urandom_range(15, 0);
            4, 5, 6:    return $urandom() & WORD_MAX;
            7:          return ($urandom_range(1, 0) != 0) ? WORD_MAX : '0;
            default:    return WORD_MAX - $urandom_range(255, 0);
        endcase
    endfunction

    // refusals, extremes, wrap and sign handling
    task automatic test_directed();
        send_request(OP_POP, 32'hffff_ffff);     // empty stack
        send_request(OP_OUT, '0);
        send_request(OP_ADD, '0);
        send_request(OP_PUSH, WORD_MIN);         // negative push
        send_request(OP_PUSH, 32'd5);
        send_request(OP_MULT, '0);               // only one entry
        send_request(OP_PUSH, '0);
        send_request(OP_PUSH, 32'd7);
        send_request(OP_DIV, '0);                // divisor below top is zero
        send_request(OP_SUB, '0);
        send_request(OP_SUB, '0);
        send_request(OP_PUSH, '0);
        send_request(OP_SUB, '0);                // 0 - 2 is negative
        send_request(OP_DIV, '0);
        send_request(OP_PUSH, WORD_MAX);
        send_request(OP_PUSH, WORD_MAX);
        send_request(OP_ADD, '0);                // wraps to -2
        send_request(OP_PUSH, 32'd1);
        send_request(OP_ADD, '0);                // -1
        send_request(OP_PUSH, 32'd1);
        send_request(OP_PUSH, WORD_MAX);
        send_request(OP_ADD, '0);                // most negative value
        send_request(OP_DIV, '0);                // most negative over minus one
        send_request(OP_OUT, '0);
        send_request(OPC_NOP, 32'hffff_ffff);
        send_request(OP_POP, 32'h5a5a_5a5a);
    endtask

    // random programs that mostly stay legal, with some noise mixed in
    task automatic test_random_programs();
        int               pick;
        logic [OP_W-1:0]  opc;
        logic [WORD_W-1:0] pv;
        for (int i = 0; i < RANDOM_REQUESTS; i++) begin
            // one stretch with no idling on either side
            tx_idle_en = !(i >= 120 && i < 180);
            rx_idle_en = tx_idle_en;
            pv = pick_push_value();
            if ($urandom_range(99, 0) < 8) begin
                opc = OP_W'($urandom_range(7, 0));
                pv  = $urandom();
            end else begin
                pick = $urandom_range(99, 0);
                if (calc_depth < 2 || (calc_depth < 40 && pick < 35)) opc = OP_PUSH;
                else if (pick < 43) opc = OP_POP;
                else if (pick < 55) opc = OP_ADD;
                else if (pick < 67) opc = OP_SUB;
                else if (pick < 79) opc = OP_DIV;
                else if (pick < 91) opc = OP_MULT;
                else opc = OP_OUT;
            end
            send_request(opc, pv);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    // fill the stack to its last entry and knock on the limit
    task automatic test_full_stack();
        while (calc_depth < STACK_DEPTH_D) send_request(OP_PUSH, pick_push_value());
        send_request(OP_PUSH, 32'd1);            // full
        send_request(OP_PUSH, 32'hdead_beef);    // negative wins over full
        send_request(OP_PUSH, '0);
        send_request(OP_ADD, '0);
        send_request(OP_PUSH, WORD_MAX);
        send_request(OP_PUSH, 32'd3);            // full again
        for (int i = 0; i < 6; i++) send_request(OP_OUT, '0);
        for (int i = 0; i < 4; i++) send_request(OP_POP, '0);
    endtask

    // receiver stalls for a long stretch while requests keep coming
    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++) begin
            if (calc_depth < 2 || $urandom_range(1, 0) != 0)
                send_request(OP_PUSH, pick_push_value());
            else
                send_request(OP_W'($urandom_range(OP_MULT, OP_POP)), '0);
        end
        tx_idle_en = 1'b1;
    endtask

    // receiver side: random stalls plus the requested long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_req) begin
            hold_req = 1'b0;
            m_tready <= 1'b0;
            hold_left = HOLD_CYCLES - 1;
        end else if (!rx_idle_en) begin
            m_tready <= 1'b1;
        end else begin
            rx_gap = pick_gap();
            if (rx_gap == 0) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                hold_left = rx_gap - 1;
            end
        end
    end

    // compare each accepted result against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding: tdata %h", m_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[2:0] != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[2:0]);
                    error_count++;
                end
                if (m_tdata[34:3] != want.value) begin
                    $error("out_value: expected %h, got %h", want.value, m_tdata[34:3]);
                    error_count++;
                end
                if (m_tuser != want.valid) begin
                    $error("out_valid: expected %0d, got %0d", want.valid, m_tuser);
                    error_count++;
                end
                if (m_tdata[43:35] != want.depth) begin
                    $error("depth_after: expected %0d, got %0d", want.depth, m_tdata[43:35]);
                    error_count++;
                end
            end
        end
    end

    // watchdog: too long without any handshake on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_programs();
        test_full_stack();
        test_backpressure();
        s_tvalid <= 1'b0;
        // let the last results come out, then watch for strays
        rx_idle_en = 1'b0;
        while (pending_results.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+src
src/sce_pkg.sv
src/sce_ram.sv
src/sce_alu.sv
src/stack_calculator_engine.sv
sim/tb_top.sv
